// ===== design/rwps_pkg.sv =====
`default_nettype none
package rwps_pkg;

   // request operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // result status codes
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_NO_WHEEL = 1'b1;

   // register map (register index)
   localparam int REG_SELECTION_POWER = 0;

   // selection power limits and reset value
   localparam logic [3:0] POWER_RESET = 4'd2;
   localparam logic [3:0] POWER_MIN   = 4'd1;
   localparam logic [3:0] POWER_MAX   = 4'd10;

   typedef struct packed {
      logic               op;
      logic signed [31:0] fitness;
      logic               last_member;
      logic        [15:0] roll_frac;
   } req_type;

   typedef struct packed {
      logic [7:0] parent_index;
      logic       status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/roulette_wheel_parent_selector_unit.sv =====
`default_nettype none
// Fitness proportionate (roulette wheel) parent selector. Load requests write
// one signed fitness each into a fitness memory; the load flagged last_member
// closes the population and starts the wheel build, which walks the members
// one at a time through one shared restoring divider (one quotient bit per
// cycle) and one squaring multiplier. Weights are (f-min)/(max-min) + 0.001
// with FRAC_BITS fraction bits, or 1.0 when all fitnesses are equal, squared
// p-1 times, p being the clamped selection power, and their saturating prefix
// sums go into a second memory. A draw request first forms the target product
// of the roll and the total, then scans those prefix sums from member 0
// through the registered memory read port, one read and one compare per
// member visited, and loads the result register; it returns the first member
// whose prefix sum reaches the roll times the total, or the last member. A
// draw before a complete population returns status 1. One request is worked
// on at a time; a finished result waits in the output register while the
// next request is accepted.
module roulette_wheel_parent_selector_unit #(
   parameter int MAX_MEMBERS = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  rwps_pkg::req_type      req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rwps_pkg::rsp_type      rsp_payload,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire  [2:0]             csr_paddr,
   input  wire  [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int IW = $clog2(MAX_MEMBERS);
   localparam int CW = $clog2(MAX_MEMBERS + 1);
   localparam int WW = FRAC_BITS + 2;
   localparam int SW = $clog2(FRAC_BITS + 1);
   localparam logic [WW-1:0] ONE_FX = WW'(1) << FRAC_BITS;
   localparam logic [WW-1:0] EPS_FX = WW'(((1 << FRAC_BITS) + 500) / 1000);

   typedef enum logic [3:0] {
      S_IDLE, S_BLD_RD, S_BLD_OFF, S_BLD_DIV, S_BLD_SQ, S_BLD_ACC,
      S_DRW_MUL, S_DRW_RD, S_DRW_CMP, S_DONE
   } state_type;

   state_type          state_ff;
   logic               wheel_ready_ff;
   logic [CW-1:0]      count_ff;
   logic [31:0]        min_ff, max_ff, total_ff, span_ff, acc_ff;
   logic [IW-1:0]      idx_ff;
   logic [32:0]        rem_ff;
   logic [FRAC_BITS:0] q_ff;
   logic [SW-1:0]      step_ff;
   logic [WW-1:0]      w_ff;
   logic [3:0]         squarings_ff, sq_cnt_ff;
   logic [15:0]        roll_ff;
   logic [47:0]        target_ff;
   logic [IW-1:0]      res_idx_ff;
   logic               res_status_ff;
   logic               rsp_valid_ff;
   rwps_pkg::rsp_type  rsp_ff;
   logic [3:0]         power_ff;
   logic [31:0]        fit_q_ff, cum_q_ff;

   logic [31:0] fit_mem [MAX_MEMBERS];
   logic [31:0] cum_mem [MAX_MEMBERS];

   logic               accept, is_load, fit_we, has_room;
   logic [CW-1:0]      base_cnt;
   logic [31:0]        min_in, max_in;
   logic [32:0]        span_in, off;
   logic               off_ge, div_ge, hit, last_idx;
   logic [32:0]        rem2;
   logic [2*WW-1:0]    sq_prod;
   logic [32:0]        acc_sum;
   logic [31:0]        acc_in;
   logic [3:0]         pw_eff;
   logic               csr_wr;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign is_load     = (req_payload.op == rwps_pkg::OP_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == 1'(rwps_pkg::REG_SELECTION_POWER));
   assign csr_prdata = (csr_paddr[2] == 1'(rwps_pkg::REG_SELECTION_POWER)) ?
                       {28'd0, power_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff <= rwps_pkg::POWER_RESET;
      end else if (csr_wr) begin
         power_ff <= csr_pwdata[3:0];
      end
   end

   // clamp the power to its legal range
   always_comb begin
      pw_eff = power_ff;
      if (power_ff < rwps_pkg::POWER_MIN) pw_eff = rwps_pkg::POWER_MIN;
      if (power_ff > rwps_pkg::POWER_MAX) pw_eff = rwps_pkg::POWER_MAX;
   end

   // load path: restart after a finished wheel, track min and max
   always_comb begin
      base_cnt = wheel_ready_ff ? '0 : count_ff;
      has_room = base_cnt < CW'(MAX_MEMBERS);
      fit_we   = accept && is_load && has_room;
      min_in   = min_ff;
      max_in   = max_ff;
      if (has_room) begin
         if (base_cnt == '0) begin
            min_in = req_payload.fitness;
            max_in = req_payload.fitness;
         end else begin
            if (req_payload.fitness < $signed(min_ff)) min_in = req_payload.fitness;
            if (req_payload.fitness > $signed(max_ff)) max_in = req_payload.fitness;
         end
      end
      span_in = $signed({max_in[31], max_in}) - $signed({min_in[31], min_in});
   end

   // wheel build datapath: offset, divider step, squaring, saturating sum
   always_comb begin
      off      = $signed({fit_q_ff[31], fit_q_ff}) - $signed({min_ff[31], min_ff});
      off_ge   = off[31:0] >= span_ff;
      rem2     = {rem_ff[31:0], 1'b0};
      div_ge   = rem2 >= {1'b0, span_ff};
      sq_prod  = w_ff * w_ff;
      acc_sum  = {1'b0, acc_ff} + 33'(w_ff);
      acc_in   = acc_sum[32] ? '1 : acc_sum[31:0];
      hit      = {cum_q_ff, 16'h0000} >= target_ff;
      last_idx = (CW'(idx_ff) + CW'(1)) == count_ff;
   end

   // fitness memory: write on load, read at the walk index
   always_ff @(posedge clock) begin
      if (fit_we) begin
         fit_mem[base_cnt[IW-1:0]] <= req_payload.fitness;
      end
      fit_q_ff <= fit_mem[idx_ff];
   end

   // prefix sum memory: write during build, read during draw scan
   always_ff @(posedge clock) begin
      if (state_ff == S_BLD_ACC) begin
         cum_mem[idx_ff] <= acc_in;
      end
      cum_q_ff <= cum_mem[idx_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wheel_ready_ff <= 1'b0;
         count_ff       <= '0;
         min_ff         <= '0;
         max_ff         <= '0;
         total_ff       <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && is_load) begin
                  wheel_ready_ff <= 1'b0;
                  min_ff         <= min_in;
                  max_ff         <= max_in;
                  count_ff       <= has_room ? base_cnt + CW'(1) : base_cnt;
                  if (req_payload.last_member) begin
                     span_ff      <= span_in[31:0];
                     idx_ff       <= '0;
                     acc_ff       <= '0;
                     squarings_ff <= pw_eff - 4'd1;
                     state_ff     <= S_BLD_RD;
                  end
               end else if (accept) begin
                  roll_ff <= req_payload.roll_frac;
                  if (!wheel_ready_ff) begin
                     res_idx_ff    <= '0;
                     res_status_ff <= rwps_pkg::ST_NO_WHEEL;
                     state_ff      <= S_DONE;
                  end else begin
                     idx_ff   <= '0;
                     state_ff <= S_DRW_MUL;
                  end
               end
            end
            S_BLD_RD: begin
               state_ff <= S_BLD_OFF;
            end
            S_BLD_OFF: begin
               sq_cnt_ff <= squarings_ff;
               if (span_ff == '0) begin
                  w_ff     <= ONE_FX;
                  state_ff <= S_BLD_SQ;
               end else begin
                  q_ff     <= {{FRAC_BITS{1'b0}}, off_ge};
                  rem_ff   <= off_ge ? {1'b0, off[31:0] - span_ff} : {1'b0, off[31:0]};
                  step_ff  <= SW'(FRAC_BITS);
                  state_ff <= S_BLD_DIV;
               end
            end
            S_BLD_DIV: begin
               rem_ff  <= div_ge ? rem2 - {1'b0, span_ff} : rem2;
               q_ff    <= {q_ff[FRAC_BITS-1:0], div_ge};
               step_ff <= step_ff - SW'(1);
               if (step_ff == SW'(1)) begin
                  w_ff     <= WW'({q_ff[FRAC_BITS-1:0], div_ge}) + EPS_FX;
                  state_ff <= S_BLD_SQ;
               end
            end
            S_BLD_SQ: begin
               if (sq_cnt_ff == 4'd0) begin
                  state_ff <= S_BLD_ACC;
               end else begin
                  w_ff      <= sq_prod[FRAC_BITS+WW-1:FRAC_BITS];
                  sq_cnt_ff <= sq_cnt_ff - 4'd1;
               end
            end
            S_BLD_ACC: begin
               acc_ff <= acc_in;
               if (last_idx) begin
                  total_ff       <= acc_in;
                  wheel_ready_ff <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_BLD_RD;
               end
            end
            S_DRW_MUL: begin
               target_ff <= 48'(roll_ff) * 48'(total_ff);
               state_ff  <= S_DRW_RD;
            end
            S_DRW_RD: begin
               state_ff <= S_DRW_CMP;
            end
            S_DRW_CMP: begin
               if (hit || last_idx) begin
                  res_idx_ff    <= idx_ff;
                  res_status_ff <= rwps_pkg::ST_OK;
                  state_ff      <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_DRW_RD;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.parent_index <= 8'(res_idx_ff);
                  rsp_ff.status       <= res_status_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // a finished wheel always holds members
   assert property (@(posedge clock) disable iff (reset)
      wheel_ready_ff |-> (count_ff != '0))
      else $error("wheel ready with empty population");

   // prefix sums never fall while the wheel is built
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLD_ACC) |=> (acc_ff >= $past(acc_ff)))
      else $error("prefix sum decreased");

   // a good draw picks a loaded member
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == rwps_pkg::ST_OK) |->
      (CW'(res_idx_ff) < count_ff))
      else $error("draw index beyond population");

   // a draw without a wheel reports member zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == rwps_pkg::ST_NO_WHEEL) |->
      (rsp_ff.parent_index == 8'd0))
      else $error("failed draw carries an index");

endmodule
`default_nettype wire
